>>> src/nalfua_pkg.sv
// Shared types and constants for the NAL unit FU-A packetiser.
// No dependencies; imported by every module of the block.
package nalfua_pkg;

    // Unit length handling
    localparam int LENGTH_BITS = 24;

    // FU-A constants
    localparam logic [7:0] NRI_MASK  = 8'hE0;
    localparam logic [7:0] TYPE_MASK = 8'h1F;
    localparam logic [7:0] FU_A_TYPE = 8'd28;
    localparam logic [7:0] FU_START  = 8'h80;
    localparam logic [7:0] FU_END    = 8'h40;

    // Packet limit register
    localparam logic [15:0] LIMIT_RESET = 16'd1400;
    localparam logic [15:0] LIMIT_MIN   = 16'd3;

    // Classification queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // One classified input byte: optional two-byte prefix, then the data byte
    typedef struct packed {
        logic       has_prefix;
        logic [7:0] ind_byte;
        logic [7:0] fuh_byte;
        logic [7:0] data_byte;
        logic       pkt_end;
    } t_q_entry;

endpackage

>>> src/nal_unit_fua_packetizer_top.sv
// Top level of the NAL unit FU-A packetiser.
// Depends on nalfua_pkg, nalfua_front, nalfua_queue and nalfua_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries the bytes of one NAL unit
//   at a time, header byte first, each with the unit's total length; the
//   length is sampled on the first byte only.
//   Output channel (o_out_valid / i_out_ready) carries the packet stream one
//   byte per transaction, with packet end and last-of-input marks.
//   i_cfg_we / i_cfg_wdata write the packet limit; write only while idle.
// Path: an input byte is queued at the accepting edge and then loaded into
//   the output register once that register is free; a byte that opens a
//   fragment follows its two prefix bytes through the output register.
// Throughput: one output byte per cycle while entries wait and the receiver
//   is ready. An input byte gives one output byte, or three where it opens
//   a fragment (two prefix bytes go first); the held header of a fragmented
//   unit gives no output. The four-entry queue absorbs the prefix bursts; the
//   back end's single output register sets the one byte per cycle ceiling.
// Reset: synchronous, active low; clears the unit state, empties the queue
//   and sets the limit to 1400.
// Receiver stall: the output byte holds; the queue fills and o_in_ready
//   drops once it is full.
module nal_unit_fua_packetizer_top
    import nalfua_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_data_byte,
    input  logic [LENGTH_BITS-1:0] i_nal_length,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_packet_end,
    output logic                   o_run_last
);

    logic     accept;
    logic     push;
    t_q_entry push_entry;
    logic     pop;
    t_q_entry head;
    logic     q_empty;
    logic     q_full;

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    nalfua_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_nal_length (i_nal_length),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    nalfua_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    nalfua_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_run_last   (o_run_last)
    );

endmodule

>>> src/nalfua_front.sv
// Front end: holds the packet limit, tracks the open NAL unit and classifies
// each input byte into a queue entry. Depends on nalfua_pkg.
module nalfua_front
    import nalfua_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata,
    input  logic                   i_accept,
    input  logic [7:0]             i_data_byte,
    input  logic [LENGTH_BITS-1:0] i_nal_length,
    output logic                   o_push,
    output t_q_entry               o_entry
);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_FRAG   = 2'd2;

    logic [15:0]            r_max_pkt;
    logic [1:0]             r_mode,   n_mode;
    logic [7:0]             r_header, n_header;
    logic [LENGTH_BITS-1:0] r_left,   n_left;
    logic [15:0]            r_fill,   n_fill;
    logic                   r_first,  n_first;

    logic [15:0]            limit;
    logic [15:0]            cap;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] left_dec;
    logic [15:0]            fill_inc;
    logic                   frag_last;

    // Effective limit and per-fragment payload cap
    assign limit = (r_max_pkt < LIMIT_MIN) ? LIMIT_MIN : r_max_pkt;
    assign cap   = limit - 16'd2;
    assign len   = (i_nal_length == '0) ? {{(LENGTH_BITS-1){1'b0}}, 1'b1} : i_nal_length;

    // Classification and next state
    always_comb begin
        n_mode    = r_mode;
        n_header  = r_header;
        n_left    = r_left;
        n_fill    = r_fill;
        n_first   = r_first;
        o_push    = 1'b0;
        o_entry   = '0;
        left_dec  = '0;
        fill_inc  = '0;
        frag_last = 1'b0;
        if (i_accept) begin
            if (r_mode == MODE_IDLE &&
                    len >= {{(LENGTH_BITS-16){1'b0}}, limit}) begin
                // header of a fragmented unit: held, no output
                n_mode   = MODE_FRAG;
                n_header = i_data_byte;
                n_left   = len - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                n_fill   = '0;
                n_first  = 1'b1;
            end else if (r_mode == MODE_IDLE || r_mode == MODE_SINGLE) begin
                // pass-through packet
                left_dec = ((r_mode == MODE_IDLE) ? len : r_left)
                           - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                n_left            = left_dec;
                n_mode            = (left_dec == '0) ? MODE_IDLE : MODE_SINGLE;
                o_push            = 1'b1;
                o_entry.data_byte = i_data_byte;
                o_entry.pkt_end   = (left_dec == '0);
            end else begin
                // fragment payload byte, prefix on the first of each fragment
                left_dec  = r_left - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                fill_inc  = r_fill + 16'd1;
                frag_last = (fill_inc >= cap) || (left_dec == '0);
                o_push             = 1'b1;
                o_entry.has_prefix = (r_fill == '0);
                o_entry.ind_byte   = (r_header & NRI_MASK) | FU_A_TYPE;
                o_entry.fuh_byte   = (r_header & TYPE_MASK)
                                   | (r_first ? FU_START : 8'h00)
                                   | ((r_left <= {{(LENGTH_BITS-16){1'b0}}, cap})
                                      ? FU_END : 8'h00);
                o_entry.data_byte  = i_data_byte;
                o_entry.pkt_end    = frag_last;
                if (r_fill == '0) begin
                    n_first = 1'b0;
                end
                n_fill = frag_last ? 16'd0 : fill_inc;
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_mode  = MODE_IDLE;
                    n_fill  = '0;
                    n_first = 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pkt <= LIMIT_RESET;
            r_mode    <= MODE_IDLE;
            r_header  <= '0;
            r_left    <= '0;
            r_fill    <= '0;
            r_first   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_max_pkt <= i_cfg_wdata;
            end
            r_mode   <= n_mode;
            r_header <= n_header;
            r_left   <= n_left;
            r_fill   <= n_fill;
            r_first  <= n_first;
        end
    end

    // Checks
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != 2'd3)
        else $error("front mode register took an unused code");
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_IDLE |-> (r_fill == '0 && r_first))
        else $error("idle front left fragment state behind");

endmodule

>>> src/nalfua_queue.sv
// Short FIFO of classified entries between the front and back ends.
// Depends on nalfua_pkg for the entry type and depth.
module nalfua_queue
    import nalfua_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output t_q_entry o_head,
    output logic     o_empty,
    output logic     o_full
);

    t_q_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr;
    logic [QPTR_BITS-1:0] r_rptr;
    logic [QCNT_BITS-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

>>> src/nalfua_back.sv
// Back end: expands each queue entry into one to three output bytes and
// drives the registered output channel. Depends on nalfua_pkg.
module nalfua_back
    import nalfua_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_q_entry i_head,
    input  logic     i_empty,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output logic [7:0] o_out_byte,
    output logic     o_packet_end,
    output logic     o_run_last
);

    localparam logic [1:0] PH_IND  = 2'd0;
    localparam logic [1:0] PH_FUH  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic       r_valid;
    logic [7:0] r_byte,  n_byte;
    logic       r_end,   n_end;
    logic       r_last,  n_last;
    logic       load;

    // Output register free to take a new byte
    assign load = !i_empty && (!r_valid || i_out_ready);

    // Byte selection for the current phase
    always_comb begin
        n_phase = r_phase;
        n_byte  = i_head.data_byte;
        n_end   = i_head.pkt_end;
        n_last  = 1'b1;
        o_pop   = 1'b0;
        if (load) begin
            if (i_head.has_prefix && r_phase == PH_IND) begin
                n_byte  = i_head.ind_byte;
                n_end   = 1'b0;
                n_last  = 1'b0;
                n_phase = PH_FUH;
            end else if (i_head.has_prefix && r_phase == PH_FUH) begin
                n_byte  = i_head.fuh_byte;
                n_end   = 1'b0;
                n_last  = 1'b0;
                n_phase = PH_DATA;
            end else begin
                o_pop   = 1'b1;
                n_phase = PH_IND;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IND;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_end  <= n_end;
            r_last <= n_last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_packet_end = r_end;
    assign o_run_last   = r_last;

    // Checks
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("back phase took an unused code");
    a_prefix_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> !r_end)
        else $error("prefix byte marked as packet end");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the NAL unit FU-A packetiser top level.
// Depends on nalfua_pkg and nal_unit_fua_packetizer_top, and through it on nalfua_front, nalfua_queue and nalfua_back.
module tb_top;
    import nalfua_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        UNIT_IDLE,
        UNIT_SINGLE,
        UNIT_FRAG
    } t_unit_state;

    // One expected byte of the packet stream
    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       pkt_end;
        logic       run_last;
    } t_pkt_byte;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [15:0]            i_cfg_wdata  = '0;
    logic                   i_in_valid   = 1'b0;
    logic [7:0]             i_data_byte  = '0;
    logic [LENGTH_BITS-1:0] i_nal_length = '0;
    logic                   i_out_ready  = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [7:0]             o_out_byte;
    logic                   o_packet_end;
    logic                   o_run_last;

    // Predictor copy of the block state and the limit register
    t_unit_state            unit_state     = UNIT_IDLE;
    logic [7:0]             held_hdr       = '0;
    logic [LENGTH_BITS-1:0] bytes_left     = '0;
    logic [15:0]            frag_fill      = '0;
    logic                   first_frag_due = 1'b1;
    logic [15:0]            limit_copy     = LIMIT_RESET;

    t_pkt_byte   expected_bytes[$];
    t_pkt_byte   exp_byte;
    int          failures       = 0;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    nal_unit_fua_packetizer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_nal_length (i_nal_length),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_run_last   (o_run_last)
    );

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Works out the packet bytes caused by one accepted input byte
    function automatic void predict_packet_bytes(input logic [7:0] data,
                                                 input logic [LENGTH_BITS-1:0] len_in);
        logic [15:0]            lim;
        logic [15:0]            cap;
        logic [LENGTH_BITS-1:0] len;
        logic [7:0]             fu_hdr;
        logic                   frag_done;
        t_pkt_byte              burst[$];
        t_pkt_byte              item;

        lim = (limit_copy < LIMIT_MIN) ? LIMIT_MIN : limit_copy;
        cap = lim - 16'd2;

        // Length sampled on the first byte only; zero counts as one
        if (unit_state == UNIT_IDLE) begin
            len = (len_in == '0) ? LENGTH_BITS'(1) : len_in;
            if (len < lim) begin
                unit_state = UNIT_SINGLE;
                bytes_left = len;
            end else begin
                // header is held, nothing goes out for it
                unit_state     = UNIT_FRAG;
                held_hdr       = data;
                bytes_left     = len - 1'b1;
                frag_fill      = '0;
                first_frag_due = 1'b1;
                return;
            end
        end

        if (unit_state == UNIT_SINGLE) begin
            bytes_left = bytes_left - 1'b1;
            burst.push_back('{data, bytes_left == '0, 1'b0});
            if (bytes_left == '0) unit_state = UNIT_IDLE;
        end else begin
            // fragment opens with indicator and FU header
            if (frag_fill == '0) begin
                fu_hdr = held_hdr & TYPE_MASK;
                if (first_frag_due) fu_hdr = fu_hdr | FU_START;
                if (bytes_left <= cap) fu_hdr = fu_hdr | FU_END;
                burst.push_back('{(held_hdr & NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0});
                burst.push_back('{fu_hdr, 1'b0, 1'b0});
                first_frag_due = 1'b0;
            end
            frag_fill  = frag_fill + 1'b1;
            bytes_left = bytes_left - 1'b1;
            frag_done  = (frag_fill >= cap) || (bytes_left == '0);
            burst.push_back('{data, frag_done, 1'b0});
            if (frag_done) frag_fill = '0;
            if (bytes_left == '0) begin
                unit_state     = UNIT_IDLE;
                frag_fill      = '0;
                first_frag_due = 1'b1;
            end
        end

        foreach (burst[k]) begin
            item          = burst[k];
            item.run_last = (k == burst.size() - 1);
            expected_bytes.push_back(item);
        end
    endfunction

    // Output side: random back-pressure and comparison of each transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected output transaction: out_byte %0h", o_out_byte);
                failures++;
            end else begin
                exp_byte = expected_bytes.pop_front();
                if (o_out_byte !== exp_byte.pkt_byte) begin
                    $error("out_byte: expected %0h, actual %0h",
                           exp_byte.pkt_byte, o_out_byte);
                    failures++;
                end
                if (o_packet_end !== exp_byte.pkt_end) begin
                    $error("packet_end: expected %0b, actual %0b",
                           exp_byte.pkt_end, o_packet_end);
                    failures++;
                end
                if (o_run_last !== exp_byte.run_last) begin
                    $error("run_last: expected %0b, actual %0b",
                           exp_byte.run_last, o_run_last);
                    failures++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] data, input logic [LENGTH_BITS-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= data;
        i_nal_length <= len;
        do @(posedge i_clk); while (!o_in_ready);
        predict_packet_bytes(data, len);
        items_sent++;
    endtask

    // Whole unit: header first, then random bodies with junk in the length field
    task automatic send_unit(input logic [LENGTH_BITS-1:0] len, input logic [7:0] hdr);
        int unsigned n_bytes;
        n_bytes = (len == '0) ? 1 : len;
        send_byte(hdr, len);
        for (int unsigned k = 1; k < n_bytes; k++) begin
            send_byte(8'($urandom), LENGTH_BITS'($urandom));
        end
    endtask

    // Let all outstanding bytes come out, then allow the pipeline to settle
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        drain_outputs();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_copy  = value;
    endtask

    // Random units sized around the limit so both paths are hit; limits above 200 get short single units only
    task automatic run_random_phase(input logic [15:0] lim, input int idle_pct,
                                    input int stall_pct, input int n_items);
        int unsigned eff;
        int unsigned cap;
        int unsigned len;
        int unsigned pick;
        int          start;

        write_limit(lim);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        eff   = (lim < LIMIT_MIN) ? LIMIT_MIN : lim;
        cap   = eff - 2;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 5)
                len = $urandom_range(1, 0);
            else if (pick < 35 || eff > 200)
                len = $urandom_range(2, (eff - 1 < 24) ? eff - 1 : 24);
            else
                len = $urandom_range(eff, eff + 2 * cap + 2);
            send_unit(LENGTH_BITS'(len), 8'($urandom));
        end
    endtask

    // Reset limit: zero, one and two byte lengths, extreme header bytes
    task automatic test_reset_limit();
        send_unit(LENGTH_BITS'(0), 8'hFF);
        send_unit(LENGTH_BITS'(1), 8'h00);
        send_unit(LENGTH_BITS'(2), 8'hA5);
    endtask

    // Limits below the minimum behave as three
    task automatic test_tiny_limits();
        write_limit(16'd0);
        send_unit(LENGTH_BITS'(3), 8'hFF);
        write_limit(16'd1);
        send_unit(LENGTH_BITS'(2), 8'h00);
        write_limit(16'd2);
        send_unit(LENGTH_BITS'(3), 8'h00);
    endtask

    // Single just under the limit, fragments at the limit with a short tail
    task automatic test_fragment_split();
        write_limit(16'd5);
        send_unit(LENGTH_BITS'(4), 8'h7C);
        send_unit(LENGTH_BITS'(5), 8'h65);
    endtask

    task automatic test_back_to_back();
        run_random_phase(16'($urandom_range(12, 4)), 0, 0, 80);
    endtask

    task automatic test_sender_gaps();
        run_random_phase(LIMIT_MIN, 85, 0, 75);
    endtask

    task automatic test_receiver_stalls();
        run_random_phase(16'($urandom_range(40, 13)), 0, 85, 75);
    endtask

    task automatic test_mixed_stalls();
        run_random_phase(16'($urandom_range(24, 3)), 38, 38, 75);
    endtask

    task automatic test_max_limit();
        run_random_phase(16'hFFFF, 38, 38, 75);
    endtask

    // Largest length field: unit left open, chopped into one-byte fragments
    task automatic test_open_ended_unit();
        write_limit(LIMIT_MIN);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'($urandom), {LENGTH_BITS{1'b1}});
        repeat (10) send_byte(8'($urandom), LENGTH_BITS'($urandom));
    endtask

    // Test sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_limit();
        test_tiny_limits();
        test_fragment_split();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_stalls();
        test_max_limit();
        test_open_ended_unit();
        drain_outputs();
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
